### rtl/core/crcfd_pkg.sv
package crcfd_pkg;

   typedef enum logic [2:0] {
      PH_MAGIC = 3'd0,
      PH_ID    = 3'd1,
      PH_TTL   = 3'd2,
      PH_LEN   = 3'd3,
      PH_PAY   = 3'd4,
      PH_CRC   = 3'd5,
      PH_DONE  = 3'd6
   } phase_type;

   typedef enum logic [2:0] {
      KIND_ID      = 3'd0,
      KIND_TTL     = 3'd1,
      KIND_LEN     = 3'd2,
      KIND_PAY     = 3'd3,
      KIND_VERDICT = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      VERD_OK    = 3'd0,
      VERD_SHORT = 3'd1,
      VERD_MAGIC = 3'd2,
      VERD_LONG  = 3'd3,
      VERD_TRUNC = 3'd4,
      VERD_CRC   = 3'd5
   } verdict_type;

   localparam logic [1:0] CSR_MAGIC_HIGH = 2'd0;
   localparam logic [1:0] CSR_MAGIC_LOW  = 2'd1;
   localparam logic [1:0] CSR_MAX_LEN    = 2'd2;

   localparam logic [7:0]  MAGIC_HIGH_RESET = 8'hA5;
   localparam logic [7:0]  MAGIC_LOW_RESET  = 8'h5A;
   localparam logic [15:0] MAX_LEN_RESET    = 16'd256;

   localparam logic [15:0] CRC_INIT  = 16'hFFFF;
   localparam logic [15:0] CRC_POLY  = 16'h1021;
   localparam logic [15:0] MIN_FRAME = 16'd23;
   localparam logic [15:0] ID_LAST   = 16'd15;

   localparam int QUEUE_DEPTH_DEFAULT = 4;

   // One queue entry: an optional tentative result and an optional verdict.
   typedef struct packed {
      logic        tent_valid;
      kind_type    tent_kind;
      logic [15:0] tent_pos;
      logic [15:0] tent_value;
      logic        verd_valid;
      verdict_type verd_code;
      logic [15:0] verd_crc;
   } entry_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {data, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

### rtl/core/crc16_frame_decoder.sv
// Checks a length-prefixed frame with a CRC-16/CCITT-FALSE trailer, one received byte per
// word, and gives out id, ttl, length and payload words as they arrive and one verdict word on
// the byte flagged as the buffer end. A byte is taken every clock cycle: the parser and its
// byte-wide CRC update handle each byte combinationally and post its results into a short
// queue, from which the output stage hands out one result word per cycle while the receiver
// does not stall. A byte that yields two results (a tentative word followed by the verdict)
// gives them out one after the other, and input is stalled only when the queue of
// QUEUE_DEPTH entries is full. Each result passes through the queue and then the output
// register. The configuration registers should be written only while no buffer is in progress.
module crc16_frame_decoder
   import crcfd_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   input  logic        req_buffer_end,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_kind,
   output logic [15:0] rsp_position,
   output logic [15:0] rsp_value,
   output logic [2:0]  rsp_verdict,
   output logic        rsp_final_res,
   input  logic        csr_write_en,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   logic      accept;
   logic      push;
   entry_type push_entry;
   logic      full;
   logic      pop;
   logic      head_valid;
   entry_type head_entry;

   assign req_stall = full;
   assign accept    = req_valid && !full;

   crcfd_front u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .rx_byte      (req_rx_byte),
      .buffer_end   (req_buffer_end),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .push         (push),
      .push_entry   (push_entry)
   );

   crcfd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   crcfd_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head_valid    (head_valid),
      .head_entry    (head_entry),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_kind      (rsp_kind),
      .rsp_position  (rsp_position),
      .rsp_value     (rsp_value),
      .rsp_verdict   (rsp_verdict),
      .rsp_final_res (rsp_final_res)
   );

endmodule

### rtl/core/crcfd_front.sv
module crcfd_front
   import crcfd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        accept,
   input  logic [7:0]  rx_byte,
   input  logic        buffer_end,
   input  logic        csr_write_en,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata,
   output logic        push,
   output entry_type   push_entry
);

   phase_type   phase_ff, phase_in;
   logic [15:0] bytes_seen_ff, bytes_seen_in;
   logic [15:0] field_count_ff, field_count_in;
   logic [15:0] crc_ff, crc_in;
   logic [15:0] length_ff, length_in;
   logic [15:0] rx_crc_ff, rx_crc_in;
   logic        magic_bad_ff, magic_bad_in;
   logic        complete_ff, complete_in;

   logic [7:0]  magic_high_ff;
   logic [7:0]  magic_low_ff;
   logic [15:0] max_len_ff;

   logic [15:0] crc_upd;
   logic [15:0] len_full;
   logic        pay_last;

   assign crc_upd  = crc_byte(crc_ff, rx_byte);
   assign len_full = {rx_byte, length_ff[7:0]};
   assign pay_last = ({1'b0, field_count_ff} + 17'd1) >= {1'b0, length_ff};

   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         if (buffer_end) begin
            phase_in = PH_MAGIC;
         end else begin
            unique case (phase_ff)
               PH_MAGIC: begin
                  if (field_count_ff != 16'd0) phase_in = PH_ID;
               end
               PH_ID: begin
                  if (field_count_ff == ID_LAST) phase_in = PH_TTL;
               end
               PH_TTL: phase_in = PH_LEN;
               PH_LEN: begin
                  if (field_count_ff != 16'd0) begin
                     if (len_full > max_len_ff) begin
                        phase_in = PH_DONE;
                     end else if (len_full == 16'd0) begin
                        phase_in = PH_CRC;
                     end else begin
                        phase_in = PH_PAY;
                     end
                  end
               end
               PH_PAY: begin
                  if (pay_last) phase_in = PH_CRC;
               end
               PH_CRC: begin
                  if (field_count_ff != 16'd0) phase_in = PH_DONE;
               end
               PH_DONE: phase_in = PH_DONE;
               default: phase_in = PH_MAGIC;
            endcase
         end
      end
   end

   always_comb begin
      bytes_seen_in  = bytes_seen_ff;
      field_count_in = field_count_ff;
      crc_in         = crc_ff;
      length_in      = length_ff;
      rx_crc_in      = rx_crc_ff;
      magic_bad_in   = magic_bad_ff;
      complete_in    = complete_ff;
      push_entry     = '{tent_valid: 1'b0, tent_kind: KIND_ID, tent_pos: 16'd0,
                         tent_value: {8'd0, rx_byte}, verd_valid: 1'b0,
                         verd_code: VERD_OK, verd_crc: 16'd0};

      if (bytes_seen_ff != 16'hFFFF) bytes_seen_in = bytes_seen_ff + 16'd1;

      unique case (phase_ff)
         PH_MAGIC: begin
            if (field_count_ff == 16'd0) begin
               if (rx_byte != magic_high_ff) magic_bad_in = 1'b1;
               field_count_in = 16'd1;
            end else begin
               if (rx_byte != magic_low_ff) magic_bad_in = 1'b1;
               field_count_in = 16'd0;
            end
         end
         PH_ID: begin
            crc_in                = crc_upd;
            push_entry.tent_valid = 1'b1;
            push_entry.tent_kind  = KIND_ID;
            push_entry.tent_pos   = field_count_ff;
            field_count_in = (field_count_ff == ID_LAST) ? 16'd0 : field_count_ff + 16'd1;
         end
         PH_TTL: begin
            crc_in                = crc_upd;
            push_entry.tent_valid = 1'b1;
            push_entry.tent_kind  = KIND_TTL;
            field_count_in        = 16'd0;
         end
         PH_LEN: begin
            crc_in = crc_upd;
            if (field_count_ff == 16'd0) begin
               length_in      = {8'd0, rx_byte};
               field_count_in = 16'd1;
            end else begin
               length_in             = len_full;
               push_entry.tent_valid = 1'b1;
               push_entry.tent_kind  = KIND_LEN;
               push_entry.tent_value = len_full;
               field_count_in        = 16'd0;
            end
         end
         PH_PAY: begin
            crc_in                = crc_upd;
            push_entry.tent_valid = 1'b1;
            push_entry.tent_kind  = KIND_PAY;
            push_entry.tent_pos   = field_count_ff;
            field_count_in        = pay_last ? 16'd0 : field_count_ff + 16'd1;
         end
         PH_CRC: begin
            if (field_count_ff == 16'd0) begin
               rx_crc_in      = {8'd0, rx_byte};
               field_count_in = 16'd1;
            end else begin
               rx_crc_in      = {rx_byte, rx_crc_ff[7:0]};
               complete_in    = 1'b1;
               field_count_in = 16'd0;
            end
         end
         PH_DONE: begin
         end
         default: begin
         end
      endcase

      if (buffer_end) begin
         push_entry.verd_valid = 1'b1;
         push_entry.verd_crc   = crc_in;
         if (bytes_seen_in < MIN_FRAME) begin
            push_entry.verd_code = VERD_SHORT;
         end else if (magic_bad_in) begin
            push_entry.verd_code = VERD_MAGIC;
         end else if (length_in > max_len_ff) begin
            push_entry.verd_code = VERD_LONG;
         end else if (!complete_in) begin
            push_entry.verd_code = VERD_TRUNC;
         end else if (rx_crc_in != crc_in) begin
            push_entry.verd_code = VERD_CRC;
         end else begin
            push_entry.verd_code = VERD_OK;
         end
         bytes_seen_in  = 16'd0;
         field_count_in = 16'd0;
         crc_in         = CRC_INIT;
         length_in      = 16'd0;
         rx_crc_in      = 16'd0;
         magic_bad_in   = 1'b0;
         complete_in    = 1'b0;
      end
   end

   assign push = accept && (push_entry.tent_valid || push_entry.verd_valid);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_MAGIC;
         bytes_seen_ff  <= 16'd0;
         field_count_ff <= 16'd0;
         crc_ff         <= CRC_INIT;
         length_ff      <= 16'd0;
         rx_crc_ff      <= 16'd0;
         magic_bad_ff   <= 1'b0;
         complete_ff    <= 1'b0;
      end else if (accept) begin
         phase_ff       <= phase_in;
         bytes_seen_ff  <= bytes_seen_in;
         field_count_ff <= field_count_in;
         crc_ff         <= crc_in;
         length_ff      <= length_in;
         rx_crc_ff      <= rx_crc_in;
         magic_bad_ff   <= magic_bad_in;
         complete_ff    <= complete_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         magic_high_ff <= MAGIC_HIGH_RESET;
         magic_low_ff  <= MAGIC_LOW_RESET;
         max_len_ff    <= MAX_LEN_RESET;
      end else if (csr_write_en) begin
         priority case (csr_index)
            CSR_MAGIC_HIGH: magic_high_ff <= csr_wdata[7:0];
            CSR_MAGIC_LOW:  magic_low_ff  <= csr_wdata[7:0];
            CSR_MAX_LEN:    max_len_ff    <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

endmodule

### rtl/core/crcfd_queue.sv
module crcfd_queue
   import crcfd_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   output logic      full,
   input  logic      pop,
   output logic      head_valid,
   output entry_type head_entry
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type          entries_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = entries_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (!do_push && do_pop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

### rtl/core/crcfd_back.sv
module crcfd_back
   import crcfd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        head_valid,
   input  entry_type   head_entry,
   output logic        pop,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_kind,
   output logic [15:0] rsp_position,
   output logic [15:0] rsp_value,
   output logic [2:0]  rsp_verdict,
   output logic        rsp_final_res
);

   logic        valid_ff;
   kind_type    kind_ff;
   logic [15:0] pos_ff;
   logic [15:0] value_ff;
   verdict_type verdict_ff;
   logic        final_ff;

   logic        pend_ff;
   verdict_type pend_code_ff;
   logic [15:0] pend_crc_ff;

   logic        slot_free;

   assign slot_free = !valid_ff || !rsp_stall;
   assign pop       = head_valid && slot_free && !pend_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         pend_ff  <= 1'b0;
      end else if (slot_free) begin
         if (pend_ff) begin
            valid_ff <= 1'b1;
            pend_ff  <= 1'b0;
         end else if (head_valid) begin
            valid_ff <= 1'b1;
            pend_ff  <= head_entry.tent_valid && head_entry.verd_valid;
         end else begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (slot_free) begin
         if (pend_ff) begin
            kind_ff    <= KIND_VERDICT;
            pos_ff     <= 16'd0;
            value_ff   <= pend_crc_ff;
            verdict_ff <= pend_code_ff;
            final_ff   <= 1'b1;
         end else if (head_valid) begin
            pend_code_ff <= head_entry.verd_code;
            pend_crc_ff  <= head_entry.verd_crc;
            if (head_entry.tent_valid) begin
               kind_ff    <= head_entry.tent_kind;
               pos_ff     <= head_entry.tent_pos;
               value_ff   <= head_entry.tent_value;
               verdict_ff <= VERD_OK;
               final_ff   <= 1'b0;
            end else begin
               kind_ff    <= KIND_VERDICT;
               pos_ff     <= 16'd0;
               value_ff   <= head_entry.verd_crc;
               verdict_ff <= head_entry.verd_code;
               final_ff   <= 1'b1;
            end
         end
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_kind      = kind_ff;
   assign rsp_position  = pos_ff;
   assign rsp_value     = value_ff;
   assign rsp_verdict   = verdict_ff;
   assign rsp_final_res = final_ff;

endmodule

### tb/crc16_frame_decoder_tb.sv
module crc16_frame_decoder_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import crcfd_pkg::*;

   localparam int RX_HOLD_CYCLES = 300;
   localparam int SETTLE_CYCLES  = 8;

   typedef struct packed {
      kind_type    kind;
      logic [15:0] position;
      logic [15:0] value;
      verdict_type verdict;
      logic        final_res;
   } result_word_type;

   class frame_scoreboard;
      result_word_type expected_words[$];
      int           errors = 0;
      logic [7:0]   magic_hi = MAGIC_HIGH_RESET;
      logic [7:0]   magic_lo = MAGIC_LOW_RESET;
      logic [15:0]  len_limit = MAX_LEN_RESET;
      phase_type    phase;
      logic [15:0]  seen;
      logic [15:0]  field_idx;
      logic [15:0]  crc;
      logic [15:0]  length;
      logic [15:0]  crc_rx;
      logic         magic_wrong;
      logic         crc_taken;

      function new();
         clear_frame();
      endfunction

      static function logic [15:0] crc_step(logic [15:0] crc_in, logic [7:0] b);
         logic [15:0] c;
         c = crc_in ^ {b, 8'h00};
         repeat (8) c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
         return c;
      endfunction

      function void clear_frame();
         phase = PH_MAGIC;
         seen = '0;
         field_idx = '0;
         crc = CRC_INIT;
         length = '0;
         crc_rx = '0;
         magic_wrong = 1'b0;
         crc_taken = 1'b0;
      endfunction

      function void set_reg(logic [1:0] idx, logic [15:0] data);
         case (idx)
            CSR_MAGIC_HIGH: magic_hi = data[7:0];
            CSR_MAGIC_LOW:  magic_lo = data[7:0];
            CSR_MAX_LEN:    len_limit = data;
            default: ;
         endcase
      endfunction

      function void add_word(kind_type k, logic [15:0] pos, logic [15:0] val,
                             verdict_type v, logic fin);
         result_word_type w;
         w.kind = k;
         w.position = pos;
         w.value = val;
         w.verdict = v;
         w.final_res = fin;
         expected_words.push_back(w);
      endfunction

      // Works out the words that one accepted byte gives and queues them.
      function void absorb_byte(logic [7:0] b, logic last);
         verdict_type v;
         if (seen != 16'hFFFF) seen++;
         case (phase)
            PH_MAGIC: begin
               if (b != ((field_idx == 0) ? magic_hi : magic_lo)) magic_wrong = 1'b1;
               field_idx++;
               if (field_idx == 2) begin
                  phase = PH_ID;
                  field_idx = '0;
               end
            end
            PH_ID: begin
               crc = crc_step(crc, b);
               add_word(KIND_ID, field_idx, {8'h00, b}, VERD_OK, 1'b0);
               field_idx++;
               if (field_idx == 16) begin
                  phase = PH_TTL;
                  field_idx = '0;
               end
            end
            PH_TTL: begin
               crc = crc_step(crc, b);
               add_word(KIND_TTL, 16'h0000, {8'h00, b}, VERD_OK, 1'b0);
               phase = PH_LEN;
               field_idx = '0;
            end
            PH_LEN: begin
               crc = crc_step(crc, b);
               if (field_idx == 0) begin
                  length = {8'h00, b};
                  field_idx = 16'd1;
               end else begin
                  length = {b, length[7:0]};
                  add_word(KIND_LEN, 16'h0000, length, VERD_OK, 1'b0);
                  field_idx = '0;
                  if (length > len_limit) phase = PH_DONE;
                  else if (length == 0) phase = PH_CRC;
                  else phase = PH_PAY;
               end
            end
            PH_PAY: begin
               crc = crc_step(crc, b);
               add_word(KIND_PAY, field_idx, {8'h00, b}, VERD_OK, 1'b0);
               field_idx++;
               if (field_idx >= length) begin
                  phase = PH_CRC;
                  field_idx = '0;
               end
            end
            PH_CRC: begin
               if (field_idx == 0) begin
                  crc_rx = {8'h00, b};
                  field_idx = 16'd1;
               end else begin
                  crc_rx = {b, crc_rx[7:0]};
                  crc_taken = 1'b1;
                  field_idx = '0;
                  phase = PH_DONE;
               end
            end
            default: ;
         endcase
         if (last) begin
            if (seen < MIN_FRAME) v = VERD_SHORT;
            else if (magic_wrong) v = VERD_MAGIC;
            else if (length > len_limit) v = VERD_LONG;
            else if (!crc_taken) v = VERD_TRUNC;
            else if (crc_rx != crc) v = VERD_CRC;
            else v = VERD_OK;
            add_word(KIND_VERDICT, 16'h0000, crc, v, 1'b1);
            clear_frame();
         end
      endfunction

      task report(string msg);
         errors++;
         if (errors <= 50) $display("MISMATCH at %0t ns: %s", $realtime, msg);
      endtask

      task check_word(logic [2:0] kind, logic [15:0] position, logic [15:0] value,
                      logic [2:0] verdict, logic final_res);
         result_word_type w;
         if (expected_words.size() == 0) begin
            report($sformatf("unexpected result word, kind %0d value %h", kind, value));
            return;
         end
         w = expected_words.pop_front();
         if (kind !== w.kind)
            report($sformatf("kind %0d, expected %0d", kind, w.kind));
         if (position !== w.position)
            report($sformatf("position %0d, expected %0d", position, w.position));
         if (value !== w.value)
            report($sformatf("value %h, expected %h", value, w.value));
         if (verdict !== w.verdict)
            report($sformatf("verdict %0d, expected %0d", verdict, w.verdict));
         if (final_res !== w.final_res)
            report($sformatf("final_res %b, expected %b", final_res, w.final_res));
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        req_buffer_end = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_kind;
   logic [15:0] rsp_position;
   logic [15:0] rsp_value;
   logic [2:0]  rsp_verdict;
   logic        rsp_final_res;
   logic        csr_write_en = 1'b0;
   logic [1:0]  csr_index = CSR_MAGIC_HIGH;
   logic [15:0] csr_wdata = 16'h0000;

   frame_scoreboard book = new();
   logic [7:0]      frame_buf[$];
   int              bytes_sent = 0;
   logic            tx_calm = 1'b0;
   logic            rx_calm = 1'b0;
   logic            rx_hold_req = 1'b0;
   logic [7:0]      cur_mh = MAGIC_HIGH_RESET;
   logic [7:0]      cur_ml = MAGIC_LOW_RESET;
   logic [15:0]     cur_lim = MAX_LEN_RESET;

   crc16_frame_decoder u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_rx_byte    (req_rx_byte),
      .req_buffer_end (req_buffer_end),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_kind       (rsp_kind),
      .rsp_position   (rsp_position),
      .rsp_value      (rsp_value),
      .rsp_verdict    (rsp_verdict),
      .rsp_final_res  (rsp_final_res),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         book.check_word(rsp_kind, rsp_position, rsp_value, rsp_verdict, rsp_final_res);
      end
   end

   // The receiver stalls in random bursts, or for one long stretch when asked, and not at all once rx_calm is set.
   initial begin
      int span;
      forever begin
         @(posedge clock);
         if (rx_hold_req) begin
            rx_hold_req = 1'b0;
            rsp_stall <= 1'b1;
            repeat (RX_HOLD_CYCLES - 1) @(posedge clock);
         end else if (!rx_calm && $urandom_range(0, 2) == 0) begin
            span = $urandom_range(1, 8);
            rsp_stall <= 1'b1;
            repeat (span - 1) @(posedge clock);
         end else begin
            span = rx_calm ? 1 : $urandom_range(1, 8);
            rsp_stall <= 1'b0;
            repeat (span - 1) @(posedge clock);
         end
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic last);
      if (!tx_calm && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= b;
      req_buffer_end <= last;
      do @(posedge clock); while (req_stall);
      book.absorb_byte(b, last);
      bytes_sent++;
   endtask

   task automatic send_buffer();
      foreach (frame_buf[i]) send_byte(frame_buf[i], i == frame_buf.size() - 1);
   endtask

   task automatic wait_results_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (book.expected_words.size() != 0);
   endtask

   task automatic program_regs(input logic [7:0] mh, input logic [7:0] ml,
                               input logic [15:0] lim);
      wait_results_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index <= CSR_MAGIC_HIGH;
      csr_wdata <= {8'h00, mh};
      @(posedge clock);
      book.set_reg(CSR_MAGIC_HIGH, {8'h00, mh});
      csr_index <= CSR_MAGIC_LOW;
      csr_wdata <= {8'h00, ml};
      @(posedge clock);
      book.set_reg(CSR_MAGIC_LOW, {8'h00, ml});
      csr_index <= CSR_MAX_LEN;
      csr_wdata <= lim;
      @(posedge clock);
      book.set_reg(CSR_MAX_LEN, lim);
      csr_write_en <= 1'b0;
      cur_mh = mh;
      cur_ml = ml;
      cur_lim = lim;
   endtask

   // Lays out a frame with a correct CRC (optionally flipped), optional extra bytes after it, and
   // the last bytes cut off where a truncated buffer is wanted.
   task automatic build_frame(input logic [7:0] mh, input logic [7:0] ml,
                              input logic [15:0] len_field, input int pay_count,
                              input logic [15:0] crc_flip, input int cut, input int trail,
                              input logic extreme_id);
      logic [15:0] c;
      logic [7:0]  b;
      frame_buf.delete();
      frame_buf.push_back(mh);
      frame_buf.push_back(ml);
      c = CRC_INIT;
      for (int i = 0; i < 19 + pay_count; i++) begin
         if (i == 17) b = len_field[7:0];
         else if (i == 18) b = len_field[15:8];
         else if (extreme_id && i < 17) b = (i[0] || i == 16) ? 8'hFF : 8'h00;
         else b = 8'($urandom);
         c = frame_scoreboard::crc_step(c, b);
         frame_buf.push_back(b);
      end
      c = c ^ crc_flip;
      frame_buf.push_back(c[7:0]);
      frame_buf.push_back(c[15:8]);
      repeat (trail) frame_buf.push_back(8'($urandom));
      repeat (cut) if (frame_buf.size() > 1) void'(frame_buf.pop_back());
   endtask

   task automatic random_buffer();
      int          mode;
      int          n;
      int          lim;
      logic [7:0]  mh;
      logic [7:0]  ml;
      logic [15:0] len;
      mode = $urandom_range(0, 99);
      lim = (cur_lim < 24) ? int'(cur_lim) : 24;
      n = $urandom_range(0, lim);
      if (cur_lim >= 300 && $urandom_range(0, 15) == 0) n = $urandom_range(25, 300);
      mh = cur_mh;
      ml = cur_ml;
      if (mode < 50) begin
         build_frame(mh, ml, 16'(n), n, 16'h0000, 0,
                     ($urandom_range(0, 4) == 0) ? $urandom_range(1, 6) : 0, 1'b0);
      end else if (mode < 62) begin
         build_frame(mh, ml, 16'(n), n, 16'($urandom_range(1, 65535)), 0, 0, 1'b0);
      end else if (mode < 72) begin
         build_frame(mh, ml, 16'(n), n, 16'h0000, $urandom_range(1, n + 4), 0, 1'b0);
      end else if (mode < 80) begin
         if ($urandom_range(0, 1) == 0) mh = mh ^ 8'($urandom_range(1, 255));
         else ml = ml ^ 8'($urandom_range(1, 255));
         build_frame(mh, ml, 16'(n), n, 16'h0000, 0, 0, 1'b0);
      end else if (mode < 87) begin
         if (cur_lim == 16'hFFFF) len = 16'($urandom_range(301, 65535));
         else len = 16'($urandom_range(int'(cur_lim) + 1, 65535));
         build_frame(mh, ml, len, $urandom_range(0, 8), 16'h0000, 0, 0, 1'b0);
      end else begin
         frame_buf.delete();
         repeat ((mode < 94) ? $urandom_range(1, 22) : $urandom_range(23, 60))
            frame_buf.push_back(8'($urandom));
      end
      send_buffer();
   endtask

   task automatic run_random(input int count);
      int stop;
      stop = bytes_sent + count;
      while (bytes_sent < stop) random_buffer();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_byte(8'hFF, 1'b1);
      build_frame(MAGIC_HIGH_RESET, MAGIC_LOW_RESET, 16'h0000, 0, 16'h0000, 0, 0, 1'b1);
      foreach (frame_buf[i]) begin
         if (i == 10) wait_results_drained();
         send_byte(frame_buf[i], i == frame_buf.size() - 1);
      end

      run_random(500);
      program_regs(8'h00, 8'hFF, 16'h0000);
      run_random(450);
      program_regs(8'hFF, 8'h00, 16'hFFFF);
      rx_hold_req = 1'b1;
      run_random(450);
      program_regs(8'($urandom), 8'($urandom), 16'($urandom_range(1, 300)));
      run_random(300);
      program_regs(MAGIC_HIGH_RESET, MAGIC_LOW_RESET, 16'd40);
      tx_calm = 1'b1;
      rx_calm = 1'b1;
      run_random(200);

      wait_results_drained();
      repeat (2 * SETTLE_CYCLES) @(posedge clock);
      if (book.errors == 0 && book.expected_words.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #50ms;
      $display("Some tests failed");
      $finish;
   end

endmodule

### sim.f
rtl/core/crcfd_pkg.sv
rtl/core/crcfd_front.sv
rtl/core/crcfd_queue.sv
rtl/core/crcfd_back.sv
rtl/core/crc16_frame_decoder.sv
tb/crc16_frame_decoder_tb.sv
